// File: rtl/core/orwa_pkg.sv
// ----------------------------------------------------------------------------
// orwa_pkg
// shared constants and types for the octet rate window average block
// ----------------------------------------------------------------------------
package orwa_pkg;

    // width of one octet counter sample and of one average
    localparam int DATA_W = 32;

    // default number of deltas held in the window
    localparam int WINDOW_DEF = 24;

    // divider status seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// File: rtl/core/orwa_ram.sv
// ----------------------------------------------------------------------------
// orwa_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module orwa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 24,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/orwa_div.sv
// ----------------------------------------------------------------------------
// orwa_div
// restoring radix-2 divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module orwa_div #(
    parameter int NUM_W = 37,
    parameter int DEN_W = 5,
    parameter int QUO_W = orwa_pkg::DATA_W
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [NUM_W-1:0]   dividend,
    input  logic [DEN_W-1:0]   divisor,
    output orwa_pkg::div_stat_t stat,
    output logic [QUO_W-1:0]   quotient
);

    localparam int STEP_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

    logic              busy_reg,  busy_next;
    logic              done_reg,  done_next;
    logic [STEP_W-1:0] step_reg,  step_next;
    logic [NUM_W-1:0]  quo_reg,   quo_next;
    logic [DEN_W-1:0]  rem_reg,   rem_next;
    logic [DEN_W-1:0]  den_reg,   den_next;

    logic [DEN_W:0]    shifted;
    logic [DEN_W+1:0]  diff;
    logic              fits;

    // one shift and trial subtract
    always_comb
    begin
        shifted = {rem_reg, quo_reg[NUM_W-1]};
        diff    = {1'b0, shifted} - {2'b00, den_reg};
        fits    = ~diff[DEN_W+1];
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
            quo_next  = {quo_reg[NUM_W-2:0], fits};
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg[QUO_W-1:0];

endmodule

// File: rtl/core/orwa_ctrl.sv
// ----------------------------------------------------------------------------
// orwa_ctrl
// sample sequencer: deltas, window store, running sums, divider control
// ----------------------------------------------------------------------------
module orwa_ctrl #(
    parameter int WINDOW = orwa_pkg::WINDOW_DEF,
    localparam int CNT_W = $clog2(WINDOW + 1),
    localparam int SUM_W = orwa_pkg::DATA_W + CNT_W
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // sample request
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [orwa_pkg::DATA_W-1:0]   rx_count,
    input  logic [orwa_pkg::DATA_W-1:0]   tx_count,
    // divider
    output logic                          div_start,
    output logic [SUM_W-1:0]              div_dividend,
    output logic [CNT_W-1:0]              div_divisor,
    input  orwa_pkg::div_stat_t           div_stat,
    input  logic [orwa_pkg::DATA_W-1:0]   div_quotient,
    // result request
    output logic                          res_valid,
    input  logic                          res_ready,
    output logic [orwa_pkg::DATA_W-1:0]   rx_average,
    output logic [orwa_pkg::DATA_W-1:0]   tx_average,
    output logic                          average_valid
);

    localparam int DW     = orwa_pkg::DATA_W;
    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_UPD     = 8'b0000_0010,
        ST_SUB     = 8'b0000_0100,
        ST_RX_GO   = 8'b0000_1000,
        ST_RX_WAIT = 8'b0001_0000,
        ST_TX_GO   = 8'b0010_0000,
        ST_TX_WAIT = 8'b0100_0000,
        ST_OUT     = 8'b1000_0000
    } state_t;

    state_t            state_reg,  state_next;
    logic [DW-1:0]     prev_rx_reg, prev_rx_next;
    logic [DW-1:0]     prev_tx_reg, prev_tx_next;
    logic [SUM_W-1:0]  rx_sum_reg, rx_sum_next;
    logic [SUM_W-1:0]  tx_sum_reg, tx_sum_next;
    logic [CNT_W-1:0]  fill_reg,   fill_next;
    logic [SLOT_W-1:0] oldest_reg, oldest_next;
    logic [DW-1:0]     drx_reg,    drx_next;
    logic [DW-1:0]     dtx_reg,    dtx_next;
    logic [DW-1:0]     rx_avg_reg, rx_avg_next;
    logic [DW-1:0]     tx_avg_reg, tx_avg_next;
    logic              valid_reg,  valid_next;

    logic              full;
    logic [SLOT_W:0]   slot_sum;
    logic [SLOT_W-1:0] free_slot;
    logic [SLOT_W-1:0] oldest_inc;

    logic              ram_we;
    logic [SLOT_W-1:0] ram_waddr;
    logic [2*DW-1:0]   ram_rdata;

    // window slot arithmetic
    always_comb
    begin
        full     = (fill_reg == CNT_W'(WINDOW));
        slot_sum = {1'b0, oldest_reg} + (SLOT_W+1)'(fill_reg);
        if (slot_sum >= (SLOT_W+1)'(WINDOW))
        begin
            slot_sum = slot_sum - (SLOT_W+1)'(WINDOW);
        end
        free_slot  = slot_sum[SLOT_W-1:0];
        oldest_inc = (oldest_reg == SLOT_W'(WINDOW - 1)) ? '0 : oldest_reg + 1'b1;
    end

    // delta store, rx delta in the low half
    orwa_ram #(
        .WIDTH (2 * DW),
        .DEPTH (WINDOW)
    ) u_delta_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({dtx_reg, drx_reg}),
        .raddr (oldest_reg),
        .rdata (ram_rdata)
    );

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        prev_rx_next = prev_rx_reg;
        prev_tx_next = prev_tx_reg;
        rx_sum_next  = rx_sum_reg;
        tx_sum_next  = tx_sum_reg;
        fill_next    = fill_reg;
        oldest_next  = oldest_reg;
        drx_next     = drx_reg;
        dtx_next     = dtx_reg;
        rx_avg_next  = rx_avg_reg;
        tx_avg_next  = tx_avg_reg;
        valid_next   = valid_reg;
        ram_we       = 1'b0;
        ram_waddr    = free_slot;
        div_start    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    prev_rx_next = rx_count;
                    prev_tx_next = tx_count;
                    drx_next     = rx_count - prev_rx_reg;
                    dtx_next     = tx_count - prev_tx_reg;
                    if (prev_rx_reg == '0 && prev_tx_reg == '0)
                    begin
                        // priming sample, window unchanged
                        if (fill_reg == '0)
                        begin
                            rx_avg_next = '0;
                            tx_avg_next = '0;
                            valid_next  = 1'b0;
                            state_next  = ST_OUT;
                        end
                        else
                        begin
                            state_next = ST_RX_GO;
                        end
                    end
                    else
                    begin
                        state_next = ST_UPD;
                    end
                end
            end
            ST_UPD:
            begin
                // add new deltas; a full window reads the oldest pair meanwhile
                rx_sum_next = rx_sum_reg + SUM_W'(drx_reg);
                tx_sum_next = tx_sum_reg + SUM_W'(dtx_reg);
                if (full)
                begin
                    state_next = ST_SUB;
                end
                else
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = free_slot;
                    fill_next  = fill_reg + 1'b1;
                    state_next = ST_RX_GO;
                end
            end
            ST_SUB:
            begin
                // drop the oldest pair and overwrite its slot
                rx_sum_next = rx_sum_reg - SUM_W'(ram_rdata[DW-1:0]);
                tx_sum_next = tx_sum_reg - SUM_W'(ram_rdata[2*DW-1:DW]);
                ram_we      = 1'b1;
                ram_waddr   = oldest_reg;
                oldest_next = oldest_inc;
                state_next  = ST_RX_GO;
            end
            ST_RX_GO:
            begin
                div_start  = 1'b1;
                state_next = ST_RX_WAIT;
            end
            ST_RX_WAIT:
            begin
                if (div_stat.done)
                begin
                    rx_avg_next = div_quotient;
                    state_next  = ST_TX_GO;
                end
            end
            ST_TX_GO:
            begin
                div_start  = 1'b1;
                state_next = ST_TX_WAIT;
            end
            ST_TX_WAIT:
            begin
                if (div_stat.done)
                begin
                    tx_avg_next = div_quotient;
                    valid_next  = 1'b1;
                    state_next  = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and window state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            prev_rx_reg <= '0;
            prev_tx_reg <= '0;
            rx_sum_reg  <= '0;
            tx_sum_reg  <= '0;
            fill_reg    <= '0;
            oldest_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            prev_rx_reg <= prev_rx_next;
            prev_tx_reg <= prev_tx_next;
            rx_sum_reg  <= rx_sum_next;
            tx_sum_reg  <= tx_sum_next;
            fill_reg    <= fill_next;
            oldest_reg  <= oldest_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        drx_reg    <= drx_next;
        dtx_reg    <= dtx_next;
        rx_avg_reg <= rx_avg_next;
        tx_avg_reg <= tx_avg_next;
        valid_reg  <= valid_next;
    end

    assign in_ready      = (state_reg == ST_IDLE);
    assign div_dividend  = (state_reg == ST_TX_GO) ? tx_sum_reg : rx_sum_reg;
    assign div_divisor   = fill_reg;
    assign res_valid     = (state_reg == ST_OUT);
    assign rx_average    = rx_avg_reg;
    assign tx_average    = tx_avg_reg;
    assign average_valid = valid_reg;

endmodule

// File: rtl/core/octet_rate_window_average_top.sv
// flow: add the deltas to the sums, drop the oldest pair on a full window, then divide
//   each sum by the fill; one radix-2 divider shared by both averages, 1 bit/cycle
// priming an empty window skips the divider; a new sample is taken once the last result
//   has left; the result register frees the sequencer while a result waits downstream
// reset: rst_n asynchronous active low, clears previous samples, sums, fill and slot;
//   the delta ram is not cleared, a slot is only read after it was written
// ----------------------------------------------------------------------------
// octet_rate_window_average_top
// moving average of rx and tx octet counter deltas over a sliding window
// ----------------------------------------------------------------------------
module octet_rate_window_average_top #(
    parameter int WINDOW = orwa_pkg::WINDOW_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // sample stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // rx_count [31:0], tx_count [63:32]
    // average stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // rx_average [31:0], tx_average [63:32]
    output logic        m_tuser    // average_valid [0]
);

    localparam int DW    = orwa_pkg::DATA_W;
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int SUM_W = DW + CNT_W;

    logic                div_start;
    logic [SUM_W-1:0]    div_dividend;
    logic [CNT_W-1:0]    div_divisor;
    orwa_pkg::div_stat_t div_stat;
    logic [DW-1:0]       div_quotient;

    logic                res_valid;
    logic                res_ready;
    logic [DW-1:0]       rx_average;
    logic [DW-1:0]       tx_average;
    logic                average_valid;

    logic                out_valid_reg;
    logic [2*DW-1:0]     out_data_reg;
    logic                out_user_reg;

    orwa_ctrl #(
        .WINDOW (WINDOW)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .rx_count      (s_tdata[DW-1:0]),
        .tx_count      (s_tdata[2*DW-1:DW]),
        .div_start     (div_start),
        .div_dividend  (div_dividend),
        .div_divisor   (div_divisor),
        .div_stat      (div_stat),
        .div_quotient  (div_quotient),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .rx_average    (rx_average),
        .tx_average    (tx_average),
        .average_valid (average_valid)
    );

    orwa_div #(
        .NUM_W (SUM_W),
        .DEN_W (CNT_W),
        .QUO_W (DW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (div_quotient)
    );

    // output register
    assign res_ready = ~out_valid_reg | m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_data_reg <= {tx_average, rx_average};
            out_user_reg <= average_valid;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule
